// ===== rtl/yuv2rgb_pkg.sv =====
// Shared widths, fixed-point coefficients and stage types for the 4:2:2 to RGB converter.
`default_nettype none
package yuv2rgb_pkg;

   localparam int COEF_FRAC_BITS = 12;
   localparam int COEF_W         = COEF_FRAC_BITS + 3;
   localparam int OPND_W         = 10;
   localparam int PROD_W         = COEF_W + OPND_W;
   localparam int ACC_W          = PROD_W + 2;
   localparam int PIX_W          = 8;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic        [PIX_W-1:0]  pix_type;

   function automatic longint fix_coef(input longint micro);
      return ((micro << COEF_FRAC_BITS) + 500000) / 1000000;
   endfunction

   localparam coef_type LIM_Y  = COEF_W'(fix_coef(1164000));
   localparam coef_type LIM_RV = COEF_W'(fix_coef(1596000));
   localparam coef_type LIM_GU = COEF_W'(fix_coef(391000));
   localparam coef_type LIM_GV = COEF_W'(fix_coef(813000));
   localparam coef_type LIM_BU = COEF_W'(fix_coef(2018000));
   localparam coef_type FUL_Y  = COEF_W'(longint'(1) << COEF_FRAC_BITS);
   localparam coef_type FUL_RV = COEF_W'(fix_coef(1402000));
   localparam coef_type FUL_GU = COEF_W'(fix_coef(344136));
   localparam coef_type FUL_GV = COEF_W'(fix_coef(714136));
   localparam coef_type FUL_BU = COEF_W'(fix_coef(1772000));

   localparam logic MODE_LIMITED = 1'b0;
   localparam logic MODE_FULL    = 1'b1;

   localparam logic [PIX_W-1:0] LUMA_BLACK   = PIX_W'(16);
   localparam logic [PIX_W-1:0] CHROMA_ZERO  = PIX_W'(128);

   typedef struct packed {
      prod_type luma;
      prod_type red_v;
      prod_type green_u;
      prod_type green_v;
      prod_type blue_u;
   } prod_set_type;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } rgb_type;

endpackage
`default_nettype wire

// ===== rtl/yuv2rgb_pixel.sv =====
// Sum and clamp stages for one RGB pixel, from its luma product and the shared chroma products.
`default_nettype none
module yuv2rgb_pixel (
   input  wire                          clock,
   input  wire yuv2rgb_pkg::prod_set_type prod,
   output yuv2rgb_pkg::rgb_type          rgb
);

   yuv2rgb_pkg::acc_type red_sum_ff, green_sum_ff, blue_sum_ff;
   yuv2rgb_pkg::acc_type red_sum_in, green_sum_in, blue_sum_in;
   yuv2rgb_pkg::rgb_type rgb_ff, rgb_in;

   function automatic yuv2rgb_pkg::pix_type clamp_pix(input yuv2rgb_pkg::acc_type acc);
      if (acc[yuv2rgb_pkg::ACC_W-1]) begin
         return '0;
      end else if (|acc[yuv2rgb_pkg::ACC_W-1:yuv2rgb_pkg::COEF_FRAC_BITS+yuv2rgb_pkg::PIX_W]) begin
         return '1;
      end else begin
         return acc[yuv2rgb_pkg::COEF_FRAC_BITS+yuv2rgb_pkg::PIX_W-1:yuv2rgb_pkg::COEF_FRAC_BITS];
      end
   endfunction

   always_comb begin
      red_sum_in   = yuv2rgb_pkg::ACC_W'(prod.luma) + yuv2rgb_pkg::ACC_W'(prod.red_v);
      green_sum_in = yuv2rgb_pkg::ACC_W'(prod.luma) - yuv2rgb_pkg::ACC_W'(prod.green_u)
                   - yuv2rgb_pkg::ACC_W'(prod.green_v);
      blue_sum_in  = yuv2rgb_pkg::ACC_W'(prod.luma) + yuv2rgb_pkg::ACC_W'(prod.blue_u);
      rgb_in.red   = clamp_pix(red_sum_ff);
      rgb_in.green = clamp_pix(green_sum_ff);
      rgb_in.blue  = clamp_pix(blue_sum_ff);
   end

   always_ff @(posedge clock) begin
      red_sum_ff   <= red_sum_in;
      green_sum_ff <= green_sum_in;
      blue_sum_ff  <= blue_sum_in;
      rgb_ff       <= rgb_in;
   end

   assign rgb = rgb_ff;

endmodule
`default_nettype wire

// ===== rtl/packed_yuv422_to_rgb_converter.sv =====
// Top level of the packed 4:2:2 macropixel to RGB pixel-pair converter.
//
// Usage:
//   Drive req_luma_first, req_chroma_blue, req_luma_second and req_chroma_red
//   with start high; the transaction is taken at that clock edge. busy is
//   always low, so one macropixel may be taken on every clock.
//   Each transaction gives one result: two RGB pixels on the rsp_ ports,
//   marked by rsp_valid for exactly one cycle. The receiver cannot stall;
//   results leave in input order.
//   The result passes the operand, multiplier, sum and clamp registers in
//   that order, the first loaded at the accepting edge, and rsp_valid
//   rises together with it. Throughput: one transaction per cycle, since
//   every stage advances on every clock.
//   csr_wr_en with csr_wr_data selects the matrix: 0 limited-range BT.601,
//   1 full range with samples raised to at least 16. Write it only while
//   the pipe is empty.
//   Reset (synchronous, active high) clears the pipe valid bits and sets
//   the matrix to limited range.
`default_nettype none
module packed_yuv422_to_rgb_converter (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire  [7:0] req_luma_first,
   input  wire  [7:0] req_chroma_blue,
   input  wire  [7:0] req_luma_second,
   input  wire  [7:0] req_chroma_red,
   input  wire        csr_wr_en,
   input  wire        csr_wr_data,
   output logic       rsp_valid,
   output logic [7:0] rsp_red_first,
   output logic [7:0] rsp_green_first,
   output logic [7:0] rsp_blue_first,
   output logic [7:0] rsp_red_second,
   output logic [7:0] rsp_green_second,
   output logic [7:0] rsp_blue_second
);

   logic       mode_ff, mode_in;
   logic [3:0] valid_ff, valid_in;

   logic                  opnd_mode_ff;
   yuv2rgb_pkg::opnd_type y1_ff, y2_ff, u_ff, v_ff;
   yuv2rgb_pkg::opnd_type y1_in, y2_in, u_in, v_in;

   yuv2rgb_pkg::prod_set_type prod1_ff, prod2_ff, prod1_in, prod2_in;
   yuv2rgb_pkg::coef_type     c_y, c_rv, c_gu, c_gv, c_bu;
   yuv2rgb_pkg::prod_type     p_rv, p_gu, p_gv, p_bu;

   yuv2rgb_pkg::rgb_type rgb1, rgb2;

   function automatic logic [7:0] floor16(input logic [7:0] x);
      return (x < yuv2rgb_pkg::LUMA_BLACK) ? yuv2rgb_pkg::LUMA_BLACK : x;
   endfunction

   always_comb begin
      mode_in  = csr_wr_en ? csr_wr_data : mode_ff;
      valid_in = {valid_ff[2:0], start};
      if (mode_ff == yuv2rgb_pkg::MODE_FULL) begin
         y1_in = yuv2rgb_pkg::OPND_W'({1'b0, floor16(req_luma_first)});
         y2_in = yuv2rgb_pkg::OPND_W'({1'b0, floor16(req_luma_second)});
         u_in  = yuv2rgb_pkg::OPND_W'({1'b0, floor16(req_chroma_blue)})
               - yuv2rgb_pkg::OPND_W'(yuv2rgb_pkg::CHROMA_ZERO);
         v_in  = yuv2rgb_pkg::OPND_W'({1'b0, floor16(req_chroma_red)})
               - yuv2rgb_pkg::OPND_W'(yuv2rgb_pkg::CHROMA_ZERO);
      end else begin
         y1_in = yuv2rgb_pkg::OPND_W'({1'b0, req_luma_first})
               - yuv2rgb_pkg::OPND_W'(yuv2rgb_pkg::LUMA_BLACK);
         y2_in = yuv2rgb_pkg::OPND_W'({1'b0, req_luma_second})
               - yuv2rgb_pkg::OPND_W'(yuv2rgb_pkg::LUMA_BLACK);
         u_in  = yuv2rgb_pkg::OPND_W'({1'b0, req_chroma_blue})
               - yuv2rgb_pkg::OPND_W'(yuv2rgb_pkg::CHROMA_ZERO);
         v_in  = yuv2rgb_pkg::OPND_W'({1'b0, req_chroma_red})
               - yuv2rgb_pkg::OPND_W'(yuv2rgb_pkg::CHROMA_ZERO);
      end
   end

   always_comb begin
      if (opnd_mode_ff == yuv2rgb_pkg::MODE_FULL) begin
         c_y  = yuv2rgb_pkg::FUL_Y;
         c_rv = yuv2rgb_pkg::FUL_RV;
         c_gu = yuv2rgb_pkg::FUL_GU;
         c_gv = yuv2rgb_pkg::FUL_GV;
         c_bu = yuv2rgb_pkg::FUL_BU;
      end else begin
         c_y  = yuv2rgb_pkg::LIM_Y;
         c_rv = yuv2rgb_pkg::LIM_RV;
         c_gu = yuv2rgb_pkg::LIM_GU;
         c_gv = yuv2rgb_pkg::LIM_GV;
         c_bu = yuv2rgb_pkg::LIM_BU;
      end
      p_rv = yuv2rgb_pkg::prod_type'(c_rv) * yuv2rgb_pkg::prod_type'(v_ff);
      p_gu = yuv2rgb_pkg::prod_type'(c_gu) * yuv2rgb_pkg::prod_type'(u_ff);
      p_gv = yuv2rgb_pkg::prod_type'(c_gv) * yuv2rgb_pkg::prod_type'(v_ff);
      p_bu = yuv2rgb_pkg::prod_type'(c_bu) * yuv2rgb_pkg::prod_type'(u_ff);
      prod1_in.luma    = yuv2rgb_pkg::prod_type'(c_y) * yuv2rgb_pkg::prod_type'(y1_ff);
      prod1_in.red_v   = p_rv;
      prod1_in.green_u = p_gu;
      prod1_in.green_v = p_gv;
      prod1_in.blue_u  = p_bu;
      prod2_in.luma    = yuv2rgb_pkg::prod_type'(c_y) * yuv2rgb_pkg::prod_type'(y2_ff);
      prod2_in.red_v   = p_rv;
      prod2_in.green_u = p_gu;
      prod2_in.green_v = p_gv;
      prod2_in.blue_u  = p_bu;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= yuv2rgb_pkg::MODE_LIMITED;
         valid_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_mode_ff <= mode_ff;
      y1_ff        <= y1_in;
      y2_ff        <= y2_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      prod1_ff     <= prod1_in;
      prod2_ff     <= prod2_in;
   end

   yuv2rgb_pixel u_pixel_first (
      .clock (clock),
      .prod  (prod1_ff),
      .rgb   (rgb1)
   );

   yuv2rgb_pixel u_pixel_second (
      .clock (clock),
      .prod  (prod2_ff),
      .rgb   (rgb2)
   );

   assign busy             = 1'b0;
   assign rsp_valid        = valid_ff[3];
   assign rsp_red_first    = rgb1.red;
   assign rsp_green_first  = rgb1.green;
   assign rsp_blue_first   = rgb1.blue;
   assign rsp_red_second   = rgb2.red;
   assign rsp_green_second = rgb2.green;
   assign rsp_blue_second  = rgb2.blue;

endmodule
`default_nettype wire
